/* rtl/hsi_pkg.sv */
// Package for the hash set intersection engine: word types, request and
// status codes, hash multiplier.
// No dependencies.
`default_nettype none

package hsi_pkg;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_PROBE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_DUP   = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;
  localparam logic [1:0] STS_EMPTY = 2'd3;

  localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic        last_item;
  } req_word_t;

  typedef struct packed {
    logic        matched;
    logic [63:0] key_out;
    logic [1:0]  status;
    logic        last_out;
  } resp_word_t;

endpackage

`default_nettype wire

/* rtl/hsi_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module hsi_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/hsi_hash.sv */
// Home-slot hash: key times golden-ratio constant mod 2^64, upper 32 bits,
// reduced mod TABLE_DEPTH. Depends on hsi_pkg.
`default_nettype none

module hsi_hash
  import hsi_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [63:0]                    key,
  output logic                                done,
  output logic      [$clog2(TABLE_DEPTH)-1:0] home
);

  localparam int  IDX_W = $clog2(TABLE_DEPTH);
  localparam bit  POW2  = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam logic [31:0] C_LO = HASH_MULT[31:0];
  localparam logic [31:0] C_HI = HASH_MULT[63:32];

  logic [63:0] prod_ll;
  logic [63:0] prod_lh;
  logic [63:0] prod_hl;
  logic [31:0] p_ll_hi;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic [31:0] h32;
  logic        v1;
  logic        v2;

  // three 32x32 partial products cover bits 63:32 of the 64-bit product
  assign prod_ll = {32'd0, key[31:0]}  * {32'd0, C_LO};
  assign prod_lh = {32'd0, key[31:0]}  * {32'd0, C_HI};
  assign prod_hl = {32'd0, key[63:32]} * {32'd0, C_LO};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_ll_hi <= prod_ll[63:32];
      p_lh    <= prod_lh[31:0];
      p_hl    <= prod_hl[31:0];
    end
    if (v1) begin
      h32 <= p_ll_hi + p_lh + p_hl;
    end
  end

  if (POW2) begin : g_mask
    assign done = v2;
    assign home = h32[IDX_W-1:0];
  end else begin : g_rem
    // reciprocal multiply: q = (h32 * RECIP) >> (32 + IDX_W) is exact for any
    // 32-bit h32; only the low IDX_W bits of q and of q * TABLE_DEPTH matter
    localparam logic [64:0] RECIP =
      ((65'd1 << (32 + IDX_W)) + 65'(TABLE_DEPTH) - 65'd1) / 65'(TABLE_DEPTH);
    localparam logic [31:0]      RECIP_LO = RECIP[31:0];
    localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(TABLE_DEPTH);
    logic [31:0]      hq;
    logic [63:0]      pm;
    logic [64:0]      sum;
    logic [IDX_W-1:0] h_lo;
    logic [IDX_W-1:0] q_lo;
    logic [IDX_W-1:0] qd_lo;
    logic [IDX_W-1:0] rem;
    logic             w1;
    logic             w2;
    logic             w3;

    // RECIP lies in [2^32, 2^33): its top bit contributes h32 << 32
    assign sum   = {1'b0, hq, 32'd0} + {1'b0, pm};
    assign qd_lo = q_lo * DEPTH_LO;

    always_ff @(posedge clk) begin
      if (rst) begin
        w1 <= 1'b0;
        w2 <= 1'b0;
        w3 <= 1'b0;
      end else begin
        w1 <= v2;
        w2 <= w1;
        w3 <= w2;
      end
    end

    always_ff @(posedge clk) begin
      if (v2) begin
        hq <= h32;
        pm <= {32'd0, h32} * {32'd0, RECIP_LO};
      end
      if (w1) begin
        h_lo <= hq[IDX_W-1:0];
        q_lo <= sum[32 + IDX_W +: IDX_W];
      end
      if (w2) begin
        rem <= h_lo - qd_lo;
      end
    end

    assign done = w3;
    assign home = rem;
  end

endmodule

`default_nettype wire

/* rtl/hash_set_intersection.sv */
// channel | signals                      | word         | direction
// req     | req_valid, req_ready, req    | req_word_t   | in
// resp    | resp_valid, resp_ready, resp | resp_word_t  | out
//
// Insert or probe: the key is hashed (with a modulo reduction when TABLE_DEPTH is
// not a power of two), then slots are inspected one per cycle from the table RAM
// read port. An empty key or unused request goes straight to the result.
// Clear: the table is swept one RAM row per cycle, then the result is returned.
// After reset the table is swept the same way with req_ready low.
// A finished word waits in the resp register; a new word is taken meanwhile.
// Depends on hsi_pkg, hsi_ram, hsi_hash.
`default_nettype none

module hash_set_intersection
  import hsi_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int KEY_BYTES   = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire req_word_t  req,
  output logic            resp_valid,
  input  wire logic       resp_ready,
  output resp_word_t      resp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]       state;
  logic [1:0]       req_code;
  logic [KEY_W-1:0] key_r;
  logic             last_r;
  logic             res_matched;
  logic [1:0]       res_status;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] chk_slot;
  logic [IDX_W-1:0] checked;
  logic [IDX_W-1:0] sweep;
  logic [CNT_W-1:0] fill_count;
  logic             pend;

  logic             accept;
  logic [KEY_W-1:0] key_m;
  logic             key_zero;
  logic             hash_start;
  logic             hash_done;
  logic [IDX_W-1:0] home;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W:0]   wr_data;
  logic             rd_en;
  logic [KEY_W:0]   rd_data;

  logic             hit;
  logic             free;
  logic             last_check;
  logic             insert_ok;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign key_m      = req.key[KEY_W-1:0];
  assign key_zero   = (key_m == '0);
  assign hash_start = accept && !key_zero &&
                      (req.req_type == REQ_INSERT || req.req_type == REQ_PROBE);

  hsi_hash #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (64'(key_m)),
    .done  (hash_done),
    .home  (home)
  );

  // read data belongs to chk_slot when pend is set
  assign hit        = pend && rd_data[KEY_W] && (rd_data[KEY_W-1:0] == key_r);
  assign free       = pend && !rd_data[KEY_W];
  assign last_check = pend && (checked == LAST_SLOT);
  assign insert_ok  = (state == S_SEARCH) && (req_code == REQ_INSERT) && !hit && free &&
                      (fill_count < CNT_W'(TABLE_DEPTH));

  assign rd_en = (state == S_SEARCH);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = '0;
    if (state == S_INIT || state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (insert_ok) begin
      wr_en   = 1'b1;
      wr_addr = chk_slot;
      wr_data = {1'b1, key_r};
    end
  end

  hsi_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep      <= '0;
      fill_count <= '0;
      pend       <= 1'b0;
      checked    <= '0;
      resp_valid <= 1'b0;
    end else begin
      if (resp_valid && resp_ready) begin
        resp_valid <= 1'b0;
      end
      case (state)
        S_INIT, S_CLEAR: begin
          sweep      <= sweep + 1'b1;
          fill_count <= '0;
          if (sweep == LAST_SLOT) begin
            sweep <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_RESULT;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (hash_start) begin
              state <= S_HASH;
            end else if (req.req_type == REQ_CLEAR) begin
              state <= S_CLEAR;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_HASH: begin
          pend    <= 1'b0;
          checked <= '0;
          if (hash_done) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          pend <= 1'b1;
          if (pend) begin
            if (hit || free || last_check) begin
              pend  <= 1'b0;
              state <= S_RESULT;
            end else begin
              checked <= checked + 1'b1;
            end
          end
          if (insert_ok) begin
            fill_count <= fill_count + 1'b1;
          end
        end
        S_RESULT: begin
          if (!resp_valid || resp_ready) begin
            resp_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_code    <= req.req_type;
      key_r       <= key_m;
      last_r      <= req.last_item;
      res_matched <= 1'b0;
      res_status  <= (hash_start || !key_zero ||
                      (req.req_type != REQ_INSERT && req.req_type != REQ_PROBE))
                     ? STS_OK : STS_EMPTY;
    end
    if (state == S_HASH && hash_done) begin
      slot <= home;
    end else if (state == S_SEARCH) begin
      slot     <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      chk_slot <= slot;
      if (pend && (hit || free || last_check)) begin
        if (req_code == REQ_PROBE) begin
          res_matched <= hit;
        end else if (hit) begin
          res_status <= STS_DUP;
        end else if (!insert_ok) begin
          res_status <= STS_FULL;
        end
      end
    end
    if (state == S_RESULT && (!resp_valid || resp_ready)) begin
      resp.matched  <= res_matched;
      resp.key_out  <= 64'(key_r);
      resp.status   <= res_status;
      resp.last_out <= last_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/hsi_checker.sv */
// Port-level checks for hash_set_intersection, bound to the top level.
// Depends on hsi_pkg.
`default_nettype none

module hsi_checker
  import hsi_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire req_word_t  req,
  input wire logic       resp_valid,
  input wire logic       resp_ready,
  input wire resp_word_t resp
);

  // a stalled result word holds
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp))
    else $error("resp word changed while stalled");

  // a match is always reported with ok status
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.matched |-> resp.status == STS_OK)
    else $error("match with non-ok status");

  // empty-key status only for a zero key, never a match
  a_empty_key: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status == STS_EMPTY |-> resp.key_out == 64'd0 && !resp.matched)
    else $error("empty status with nonzero key or match");

  // table sweep after reset keeps the request side closed
  a_init_closed: assert property (@(posedge clk)
    rst |=> !req_ready && !resp_valid)
    else $error("ready or valid right after reset");

endmodule

bind hash_set_intersection hsi_checker u_hsi_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Testbench for hash_set_intersection: random and directed insert, probe, clear and unused words,
// each response checked against a behavioral model of the hash table kept here.
// Depends on hsi_pkg and the hash_set_intersection RTL.
`default_nettype none

module tb
  import hsi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4096;
  localparam int KEY_BYTES = 8;
  localparam int HBITS = $clog2(DEPTH);
  localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
  // request code the block treats as a no-op
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_word_t req = '0;
  logic resp_valid;
  logic resp_ready = 1'b0;
  resp_word_t resp;

  // model of the table
  logic [63:0] slot_key [DEPTH];
  bit slot_used [DEPTH];
  int unsigned used_count = 0;

  resp_word_t pending_resp [$];
  resp_word_t due_word;
  int errors = 0;
  bit steady = 1'b0;
  int unsigned stall_left = 0;
  logic [63:0] hash_inv;

  hash_set_intersection #(
    .TABLE_DEPTH(DEPTH),
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .resp_valid(resp_valid),
    .resp_ready(resp_ready),
    .resp(resp)
  );

  always #5 clk = ~clk;

  function automatic int unsigned home_slot(logic [63:0] k);
    logic [63:0] p;
    p = k * HASH_MULT;
    return p[63:32] % DEPTH;
  endfunction

  // key whose hash lands on a chosen slot: pick the product, undo the multiply
  function automatic logic [63:0] key_with_home(int unsigned s);
    logic [63:0] p;
    logic [63:0] k;
    do begin
      p = {$urandom, $urandom};
      p[32 +: HBITS] = s[HBITS-1:0];
      k = p * hash_inv;
    end while (k == '0);
    return k;
  endfunction

  function automatic resp_word_t table_response(req_word_t w);
    resp_word_t r;
    logic [63:0] k;
    int unsigned s;
    int found;
    k = w.key & KEY_MASK;
    r.matched = 1'b0;
    r.key_out = k;
    r.status = STS_OK;
    r.last_out = w.last_item;
    if (w.req_type == REQ_INSERT || w.req_type == REQ_PROBE) begin
      if (k == '0) begin
        r.status = STS_EMPTY;
      end else begin
        // linear probe: 1 hit, 0 free slot, -1 whole table walked
        s = home_slot(k);
        found = -1;
        for (int n = 0; n < DEPTH; n++) begin
          if (!slot_used[s]) begin
            found = 0;
            break;
          end
          if (slot_key[s] == k) begin
            found = 1;
            break;
          end
          s = (s == DEPTH - 1) ? 0 : s + 1;
        end
        if (w.req_type == REQ_PROBE) begin
          r.matched = (found == 1);
        end else if (found == 1) begin
          r.status = STS_DUP;
        end else if (found < 0 || used_count >= DEPTH) begin
          r.status = STS_FULL;
        end else begin
          slot_key[s] = k;
          slot_used[s] = 1'b1;
          used_count++;
        end
      end
    end else if (w.req_type == REQ_CLEAR) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      used_count = 0;
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [1:0] kind, logic [63:0] k, logic last);
    req_word_t w;
    int unsigned gap;
    w.req_type = kind;
    w.key = k;
    w.last_item = last;
    gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_resp.push_back(table_response(w));
  endtask

  // drop valid and hold off until every response is back
  task automatic wait_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    // three keys sharing the last slot, so probing wraps to slot 0
    ka = key_with_home(DEPTH - 1);
    do kb = key_with_home(DEPTH - 1); while (kb == ka);
    do kc = key_with_home(DEPTH - 1); while (kc == ka || kc == kb);
    send_word(REQ_PROBE, 64'd1, 1'b0);
    send_word(REQ_INSERT, {64{1'b1}}, 1'b0);
    send_word(REQ_INSERT, 64'd1, 1'b0);
    send_word(REQ_INSERT, 64'd1, 1'b1);
    send_word(REQ_PROBE, 64'd1, 1'b1);
    send_word(REQ_PROBE, {64{1'b1}}, 1'b0);
    send_word(REQ_PROBE, 64'd2, 1'b0);
    send_word(REQ_INSERT, 64'd0, 1'b0);
    send_word(REQ_PROBE, 64'd0, 1'b1);
    send_word(REQ_INSERT, ka, 1'b0);
    send_word(REQ_INSERT, kb, 1'b0);
    send_word(REQ_PROBE, kb, 1'b0);
    send_word(REQ_PROBE, kc, 1'b0);
    send_word(REQ_INSERT, kc, 1'b1);
    send_word(REQ_PROBE, ka, 1'b0);
    send_word(REQ_UNUSED, 64'hDEAD_BEEF_0123_4567, 1'b1);
    send_word(REQ_PROBE, 64'hDEAD_BEEF_0123_4567, 1'b0);
    send_word(REQ_INSERT, 64'h8000_0000_0000_0000, 1'b0);
    send_word(REQ_CLEAR, {$urandom, $urandom}, 1'b1);
    send_word(REQ_PROBE, 64'd1, 1'b0);
    send_word(REQ_PROBE, kc, 1'b0);
    send_word(REQ_INSERT, 64'd1, 1'b1);
    wait_results();
  endtask

  task automatic test_random(int unsigned count);
    logic [63:0] pool [64];
    int unsigned pick;
    logic [1:0] kind;
    logic [63:0] k;
    // about half the pool clusters around the wrap point
    foreach (pool[i]) begin
      pick = ($urandom_range(0, 1) == 0) ? (DEPTH - 3 + $urandom_range(0, 5)) % DEPTH
                                         : $urandom_range(0, DEPTH - 1);
      pool[i] = key_with_home(pick);
    end
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == count / 2) wait_results();
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? REQ_INSERT : (pick < 85) ? REQ_PROBE :
             (pick < 88) ? REQ_CLEAR : REQ_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 78) k = pool[$urandom_range(0, 63)];
      else if (pick < 94) k = {$urandom, $urandom};
      else if (pick < 97) k = 64'd1 << $urandom_range(0, 63);
      else k = '0;
      send_word(kind, k, 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
    wait_results();
  endtask

  // response side back-pressure
  always @(negedge clk) begin
    if (steady) begin
      stall_left = 0;
      resp_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      resp_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 75) begin
      resp_ready <= 1'b1;
    end else begin
      stall_left = idle_len() - 1;
      resp_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && resp_valid && resp_ready) begin
      if (pending_resp.size() == 0) begin
        $error("response word with nothing pending, key_out %h", resp.key_out);
        errors++;
      end else begin
        due_word = pending_resp.pop_front();
        if (resp.matched !== due_word.matched) begin
          $error("matched: expected %0d, got %0d", due_word.matched, resp.matched);
          errors++;
        end
        if (resp.key_out !== due_word.key_out) begin
          $error("key_out: expected %h, got %h", due_word.key_out, resp.key_out);
          errors++;
        end
        if (resp.status !== due_word.status) begin
          $error("status: expected %0d, got %0d", due_word.status, resp.status);
          errors++;
        end
        if (resp.last_out !== due_word.last_out) begin
          $error("last_out: expected %0d, got %0d", due_word.last_out, resp.last_out);
          errors++;
        end
      end
    end
  end

  initial begin
    // inverse of the odd multiplier mod 2^64 by Newton iteration
    hash_inv = HASH_MULT;
    repeat (6) hash_inv = hash_inv * (64'd2 - HASH_MULT * hash_inv);
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(430);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
